// ----- sv/uer_pkg.sv -----
// ----------------------------------------------------------------------------
// uer_pkg: shared types and constants for the ultrasonic echo ranger
// Holds the item types, the phase and status codes, the register indexes and
// the constants of the reciprocal divider.
// ----------------------------------------------------------------------------
package uer_pkg;

    // Width of the tick counter and the number of ticks that make one centimetre.
    localparam int COUNT_BITS   = 24;
    localparam int TICKS_PER_CM = 928;
    localparam int DIVISOR      = (TICKS_PER_CM > 0) ? TICKS_PER_CM : 1;
    localparam int DIV_W        = 16;

    // Widths used for comparisons and the quotient.
    localparam int CMP_W = (COUNT_BITS > 24) ? COUNT_BITS : 24;
    localparam int Q_W   = (COUNT_BITS > 16) ? COUNT_BITS : 16;

    // Reciprocal of the divisor, scaled by two to the counter width.
    localparam int RECIP_W = COUNT_BITS + 1;
    localparam int PROD_W  = COUNT_BITS + RECIP_W;
    localparam int QD_W    = COUNT_BITS + DIV_W;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << COUNT_BITS) / DIVISOR);

    localparam logic [COUNT_BITS-1:0] CNT_MAX  = '1;
    localparam logic [15:0]           DIST_MAX = 16'hFFFF;

    // Register widths and reset values.
    localparam int CFG_W = 24;
    localparam logic [7:0]  SETTLE_RST  = 8'd16;
    localparam logic [15:0] PULSE_RST   = 16'd192;
    localparam logic [23:0] TIMEOUT_RST = 24'd480000;

    typedef enum logic [1:0] {
        CFG_SETTLE  = 2'd0,
        CFG_PULSE   = 2'd1,
        CFG_TIMEOUT = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_PRE   = 3'd1,
        PH_PULSE = 3'd2,
        PH_POST  = 3'd3,
        PH_WAIT  = 3'd4,
        PH_MEAS  = 3'd5
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_ECHO  = 2'd1,
        ST_TOO_LONG = 2'd2
    } t_status;

    typedef struct packed {
        logic kind;
        logic echo_level;
    } t_in_item;

    typedef struct packed {
        logic        trigger_level;
        logic        busy_res;
        logic        done_res;
        logic [1:0]  status;
        logic [15:0] distance_cm;
    } t_out_item;

    // Result of the controller for one item, before the distance is divided.
    typedef struct packed {
        logic                  trigger;
        logic                  busy;
        logic                  done;
        t_status               status;
        logic                  meas_ok;
        logic [COUNT_BITS-1:0] ticks;
    } t_part;

endpackage

// ----- sv/ultrasonic_echo_ranger_top.sv -----
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger_top: echo timer for an ultrasonic rangefinder
// Each input item is one tick of the timing base; each gives one result item
// with the trigger level, busy, done, a status and the distance in centimetres.
//
//   Channel | Direction | Signals                              | Payload
//   in      | input     | i_in_valid, o_in_ready, i_in_item    | kind, echo_level
//   out     | output    | o_out_valid, i_out_ready, o_out_item | trigger..distance_cm
//   cfg     | input     | i_cfg_we, i_cfg_idx, i_cfg_data      | settle, pulse, timeout
//
// One item is accepted per cycle unless the output stalls; the combinational
// sequencer feeds the input, product, estimate and output registers of the divider.
// Synchronous active-low reset returns to idle with the register reset values.
// A stall on the output holds the whole pipeline and drops o_in_ready.
// ----------------------------------------------------------------------------
module ultrasonic_echo_ranger_top (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  uer_pkg::t_in_item         i_in_item,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output uer_pkg::t_out_item        o_out_item,
    input  logic                      i_cfg_we,
    input  logic [1:0]                i_cfg_idx,
    input  logic [uer_pkg::CFG_W-1:0] i_cfg_data
);
    import uer_pkg::*;

    logic  accept;
    logic  div_ready;
    t_part part;

    // An item is taken when the pipeline can move.
    assign accept     = i_in_valid && div_ready;
    assign o_in_ready = div_ready;

    // Sequencer and configuration registers.
    uer_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_accept   (accept),
        .i_item     (i_in_item),
        .o_part     (part)
    );

    // Distance divider and output register.
    uer_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (div_ready),
        .i_part  (part),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_item  (o_out_item)
    );

    // A finished measurement is never still busy.
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.done_res) |-> !o_out_item.busy_res)
        else $error("done and busy together");

    // A distance is only reported with a successful measurement.
    a_dist_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_item.distance_cm != 16'd0)) |->
        (o_out_item.done_res && (o_out_item.status == ST_OK)))
        else $error("distance without a successful measurement");

    // An error status only comes with done.
    a_status_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_item.status != ST_OK)) |-> o_out_item.done_res)
        else $error("status without done");

    // The trigger is only driven high during a measurement.
    a_trig_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.trigger_level) |-> o_out_item.busy_res)
        else $error("trigger high while not busy");

endmodule

// ----- sv/uer_ctrl.sv -----
// ----------------------------------------------------------------------------
// uer_ctrl: configuration registers and measurement sequencer
// Steps the trigger, echo wait and echo measure phases once per accepted item
// and hands the partial result of that item to the divider pipeline.
// ----------------------------------------------------------------------------
module uer_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [1:0]                    i_cfg_idx,
    input  logic [uer_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_accept,
    input  uer_pkg::t_in_item             i_item,
    output uer_pkg::t_part                o_part
);
    import uer_pkg::*;

    logic [7:0]            r_settle;
    logic [15:0]           r_pulse;
    logic [23:0]           r_timeout;
    t_phase                r_phase;
    t_phase                n_phase;
    logic [COUNT_BITS-1:0] r_cnt;
    logic [COUNT_BITS-1:0] n_cnt;
    logic                  held;
    logic [15:0]           plen;
    t_part                 part;

    function automatic logic reached(input logic [COUNT_BITS-1:0] c,
                                     input logic [CMP_W-1:0] limit);
        return (CMP_W'(c) >= limit) || (c == CNT_MAX);
    endfunction

    function automatic logic [COUNT_BITS-1:0] bump(input logic [COUNT_BITS-1:0] c);
        return (c == CNT_MAX) ? CNT_MAX : c + COUNT_BITS'(1);
    endfunction

    function automatic logic expired(input logic [COUNT_BITS-1:0] c,
                                     input logic [23:0] limit);
        return (CMP_W'(c) > CMP_W'(limit)) || (c == CNT_MAX);
    endfunction

    // A pulse length of zero runs as one tick.
    assign plen = (r_pulse == 16'd0) ? 16'd1 : r_pulse;

    // Next phase and counter for the current item; zero-length phases fall through.
    always_comb begin
        n_phase = r_phase;
        n_cnt   = r_cnt;
        held    = 1'b0;
        part    = '0;
        part.status = ST_OK;

        if (r_phase > PH_MEAS) begin
            n_phase = PH_IDLE;
            n_cnt   = '0;
        end
        if (n_phase == PH_IDLE && i_item.kind) begin
            n_phase = PH_PRE;
            n_cnt   = '0;
        end
        if (n_phase == PH_PRE) begin
            if (reached(n_cnt, CMP_W'(r_settle))) begin
                n_phase = PH_PULSE;
                n_cnt   = '0;
            end else begin
                held = 1'b1;
            end
        end
        if (!held && n_phase == PH_PULSE) begin
            if (reached(n_cnt, CMP_W'(plen))) begin
                n_phase = PH_POST;
                n_cnt   = '0;
            end else begin
                held = 1'b1;
            end
        end
        if (!held && n_phase == PH_POST) begin
            if (reached(n_cnt, CMP_W'(r_settle))) begin
                n_phase = PH_WAIT;
                n_cnt   = '0;
            end else begin
                held = 1'b1;
            end
        end

        if (held) begin
            n_cnt        = bump(n_cnt);
            part.trigger = (n_phase == PH_PULSE);
            part.busy    = 1'b1;
        end else if (n_phase == PH_WAIT) begin
            if (i_item.echo_level) begin
                n_phase = PH_MEAS;
                n_cnt   = COUNT_BITS'(1);
                if (expired(n_cnt, r_timeout)) begin
                    part.done   = 1'b1;
                    part.status = ST_TOO_LONG;
                    n_phase     = PH_IDLE;
                end else begin
                    part.busy = 1'b1;
                end
            end else begin
                n_cnt = bump(n_cnt);
                if (expired(n_cnt, r_timeout)) begin
                    part.done   = 1'b1;
                    part.status = ST_NO_ECHO;
                    n_phase     = PH_IDLE;
                end else begin
                    part.busy = 1'b1;
                end
            end
        end else if (n_phase == PH_MEAS) begin
            if (i_item.echo_level) begin
                n_cnt = bump(n_cnt);
                if (expired(n_cnt, r_timeout)) begin
                    part.done   = 1'b1;
                    part.status = ST_TOO_LONG;
                    n_phase     = PH_IDLE;
                end else begin
                    part.busy = 1'b1;
                end
            end else begin
                part.done    = 1'b1;
                part.meas_ok = 1'b1;
                part.ticks   = n_cnt;
                n_phase      = PH_IDLE;
            end
        end
    end

    assign o_part = part;

    // Configuration writes and the sequencer state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_settle  <= SETTLE_RST;
            r_pulse   <= PULSE_RST;
            r_timeout <= TIMEOUT_RST;
            r_phase   <= PH_IDLE;
            r_cnt     <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_SETTLE:  r_settle  <= i_cfg_data[7:0];
                    CFG_PULSE:   r_pulse   <= i_cfg_data[15:0];
                    CFG_TIMEOUT: r_timeout <= i_cfg_data[23:0];
                    default:     ;
                endcase
            end
            if (i_accept) begin
                r_phase <= n_phase;
                r_cnt   <= n_cnt;
            end
        end
    end

endmodule

// ----- sv/uer_div.sv -----
// ----------------------------------------------------------------------------
// uer_div: distance divider pipeline and output register
// Divides the echo width by the ticks-per-centimetre constant through a
// reciprocal multiply, a back multiply and a single correction step.
// ----------------------------------------------------------------------------
module uer_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  uer_pkg::t_part     i_part,
    output logic               o_valid,
    input  logic               i_ready,
    output uer_pkg::t_out_item o_item
);
    import uer_pkg::*;

    logic                  r_v1, r_v2, r_v3, r_v4;
    t_part                 r_p1, r_p2, r_p3;
    logic [PROD_W-1:0]     r_prod;
    logic [COUNT_BITS-1:0] r_q0;
    logic [COUNT_BITS-1:0] r_qd;
    t_out_item             r_out;
    logic                  adv;
    logic [COUNT_BITS-1:0] q0;
    logic [QD_W-1:0]       qd;
    logic [COUNT_BITS-1:0] rem;
    logic [Q_W-1:0]        quot;
    logic [15:0]           dist_sat;

    // The whole pipeline moves when the output register is free or being taken.
    assign adv     = !r_v4 || i_ready;
    assign o_ready = adv;

    // Quotient estimate and its back product.
    assign q0 = COUNT_BITS'(r_prod >> COUNT_BITS);
    assign qd = QD_W'(q0) * QD_W'(DIV_W'(DIVISOR));

    // Correct the estimate by one and saturate to the distance width.
    assign rem      = r_p3.ticks - r_qd;
    assign quot     = Q_W'(r_q0) + ((Q_W'(rem) >= Q_W'(DIVISOR)) ? Q_W'(1) : Q_W'(0));
    assign dist_sat = (quot > Q_W'(DIST_MAX)) ? DIST_MAX : quot[15:0];

    // Valid bits of the stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (adv) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    // Stage data.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p1   <= i_part;
            r_p2   <= r_p1;
            r_prod <= PROD_W'(r_p1.ticks) * PROD_W'(RECIP);
            r_p3   <= r_p2;
            r_q0   <= q0;
            r_qd   <= qd[COUNT_BITS-1:0];
            r_out.trigger_level <= r_p3.trigger;
            r_out.busy_res      <= r_p3.busy;
            r_out.done_res      <= r_p3.done;
            r_out.status        <= r_p3.status;
            r_out.distance_cm   <= r_p3.meas_ok ? dist_sat : 16'd0;
        end
    end

    assign o_valid = r_v4;
    assign o_item  = r_out;

endmodule

// ----- test/uer_echo_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// uer_echo_checker: result checker for the ultrasonic echo ranger
// Watches the input, output and register channels of the ranger. Every item
// taken in is run through a cycle-true model of the measurement sequencer,
// and the result it predicts is queued. Every result item given out is
// compared field by field with the oldest queued prediction.
// ----------------------------------------------------------------------------
module uer_echo_checker (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  logic                      i_in_ready,
    input  uer_pkg::t_in_item         i_in_item,
    input  logic                      i_out_valid,
    input  logic                      i_out_ready,
    input  uer_pkg::t_out_item        i_out_item,
    input  logic                      i_cfg_we,
    input  logic [1:0]                i_cfg_idx,
    input  logic [uer_pkg::CFG_W-1:0] i_cfg_data,
    output int                        o_fail_count,
    output int                        o_pending
);

    import uer_pkg::*;

    // Model copy of the registers and of the sequencer state.
    logic [7:0]            settle_len;
    logic [15:0]           pulse_len;
    logic [23:0]           timeout_len;
    t_phase                phase_q;
    logic [COUNT_BITS-1:0] ticks_q;

    // Predicted result items, oldest first.
    t_out_item echo_results[$];
    t_out_item want;
    int        err_count  = 0;
    int        result_idx = 0;

    // Prints one line for a failure and counts it.
    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t, result %0d: %s", $realtime, result_idx, msg);
        err_count++;
    endtask

    function automatic logic [COUNT_BITS-1:0] bump(input logic [COUNT_BITS-1:0] c);
        return (c == CNT_MAX) ? c : c + 1'b1;
    endfunction

    // A saturated counter counts as having reached every limit.
    function automatic logic hit_limit(input logic [COUNT_BITS-1:0] c,
                                       input logic [31:0] lim);
        return (64'(c) >= 64'(lim)) || (c == CNT_MAX);
    endfunction

    function automatic logic timed_out(input logic [COUNT_BITS-1:0] c);
        return (64'(c) > 64'(timeout_len)) || (c == CNT_MAX);
    endfunction

    // Advances the model by one tick and returns the result item it gives.
    function automatic t_out_item ranger_tick(input logic start, input logic echo);
        t_out_item             res;
        logic                  held;
        logic [31:0]           plen;
        logic [COUNT_BITS-1:0] quot;
        res  = '0;
        held = 1'b0;
        plen = (pulse_len == '0) ? 32'd1 : 32'(pulse_len);

        // Trigger sequence: settle low, pulse high, settle low. Phases of
        // zero length fall through within the same tick.
        if (phase_q == PH_IDLE && start) begin
            phase_q = PH_PRE;
            ticks_q = '0;
        end
        if (phase_q == PH_PRE) begin
            if (hit_limit(ticks_q, 32'(settle_len))) begin
                phase_q = PH_PULSE;
                ticks_q = '0;
            end else begin
                held = 1'b1;
            end
        end
        if (!held && phase_q == PH_PULSE) begin
            if (hit_limit(ticks_q, plen)) begin
                phase_q = PH_POST;
                ticks_q = '0;
            end else begin
                held = 1'b1;
            end
        end
        if (!held && phase_q == PH_POST) begin
            if (hit_limit(ticks_q, 32'(settle_len))) begin
                phase_q = PH_WAIT;
                ticks_q = '0;
            end else begin
                held = 1'b1;
            end
        end

        // Echo wait and echo width measurement.
        if (held) begin
            ticks_q           = bump(ticks_q);
            res.trigger_level = (phase_q == PH_PULSE);
            res.busy_res      = 1'b1;
        end else if (phase_q == PH_WAIT) begin
            if (echo) begin
                phase_q = PH_MEAS;
                ticks_q = COUNT_BITS'(1);
            end else begin
                ticks_q = bump(ticks_q);
            end
            if (timed_out(ticks_q)) begin
                res.done_res = 1'b1;
                res.status   = echo ? ST_TOO_LONG : ST_NO_ECHO;
                phase_q      = PH_IDLE;
            end else begin
                res.busy_res = 1'b1;
            end
        end else if (phase_q == PH_MEAS) begin
            if (echo) begin
                ticks_q = bump(ticks_q);
                if (timed_out(ticks_q)) begin
                    res.done_res = 1'b1;
                    res.status   = ST_TOO_LONG;
                    phase_q      = PH_IDLE;
                end else begin
                    res.busy_res = 1'b1;
                end
            end else begin
                quot            = COUNT_BITS'(ticks_q / DIVISOR);
                res.distance_cm = (quot > DIST_MAX) ? DIST_MAX : quot[15:0];
                res.done_res    = 1'b1;
                res.status      = ST_OK;
                phase_q         = PH_IDLE;
            end
        end
        return res;
    endfunction

    // Prediction on accepted items, comparison on accepted results.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            settle_len  = SETTLE_RST;
            pulse_len   = PULSE_RST;
            timeout_len = TIMEOUT_RST;
            phase_q     = PH_IDLE;
            ticks_q     = '0;
            echo_results.delete();
        end else begin
            if (i_in_valid && i_in_ready) begin
                echo_results.push_back(ranger_tick(i_in_item.kind, i_in_item.echo_level));
            end
            if (i_out_valid && i_out_ready) begin
                if (echo_results.size() == 0) begin
                    report_mismatch("result item with no prediction waiting");
                end else begin
                    want = echo_results.pop_front();
                    if (i_out_item.trigger_level !== want.trigger_level)
                        report_mismatch($sformatf("trigger_level is %0d, expected %0d",
                                        i_out_item.trigger_level, want.trigger_level));
                    if (i_out_item.busy_res !== want.busy_res)
                        report_mismatch($sformatf("busy_res is %0d, expected %0d",
                                        i_out_item.busy_res, want.busy_res));
                    if (i_out_item.done_res !== want.done_res)
                        report_mismatch($sformatf("done_res is %0d, expected %0d",
                                        i_out_item.done_res, want.done_res));
                    if (i_out_item.status !== want.status)
                        report_mismatch($sformatf("status is %0d, expected %0d",
                                        i_out_item.status, want.status));
                    if (i_out_item.distance_cm !== want.distance_cm)
                        report_mismatch($sformatf("distance_cm is %0d, expected %0d",
                                        i_out_item.distance_cm, want.distance_cm));
                end
                result_idx++;
            end
            // Register writes apply from the next tick; unknown indexes are ignored.
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SETTLE:  settle_len  = i_cfg_data[7:0];
                    CFG_PULSE:   pulse_len   = i_cfg_data[15:0];
                    CFG_TIMEOUT: timeout_len = i_cfg_data[23:0];
                    default: begin
                    end
                endcase
            end
        end
        o_fail_count <= err_count;
        o_pending    <= echo_results.size();
    end

endmodule

// ----- test/tb_ultrasonic_echo_ranger_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ultrasonic_echo_ranger_top: testbench for the ultrasonic echo ranger
// Drives tick items into the ranger and takes its result items, with random
// gaps on both sides, a long output stall and a long run without gaps. A
// directed part covers the reset values, register writes during a
// measurement, zero-length phases, the longest timeout, the timeout
// boundaries and start requests while busy; random measurement sequences
// follow. The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_ultrasonic_echo_ranger_top;

    import uer_pkg::*;

    localparam int        CYCLE_LIMIT = 1_000_000;
    localparam int        LATENCY     = 4;
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    t_in_item          in_item;
    logic              out_valid;
    logic              out_ready;
    t_out_item         out_item;
    logic              cfg_we;
    logic [1:0]        cfg_idx;
    logic [CFG_W-1:0]  cfg_data;

    int fail_count;
    int pending;
    int cycle_cnt  = 0;
    int sent_items = 0;
    bit gaps_on    = 1'b1;
    bit hold_req   = 1'b0;

    // Register values as last written, used to shape measurement sequences.
    int cur_settle  = SETTLE_RST;
    int cur_pulse   = PULSE_RST;
    int cur_timeout = TIMEOUT_RST;

    ultrasonic_echo_ranger_top u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_item  (in_item),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_item (out_item),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    uer_echo_checker u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in_item   (in_item),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    // Clock.
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog on the total run length.
    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("FAIL ultrasonic_echo_ranger_top");
        $finish;
    end

    function automatic bit coin(input int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    // Result side: random stalls, or one long hold-off when asked for.
    initial begin
        int hold_left;
        hold_left = 0;
        out_ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_left == 0 && hold_req) begin
                hold_left = 80;
            end
            if (hold_left > 0) begin
                out_ready <= 1'b0;
                hold_left--;
                if (hold_left == 0) begin
                    hold_req = 1'b0;
                end
            end else begin
                out_ready <= !(gaps_on && coin(36));
            end
        end
    end

    // Offers one tick item, with random gaps ahead of it, until it is taken.
    task automatic push_tick(input logic kind, input logic echo);
        while (gaps_on && coin(36)) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= '{kind: kind, echo_level: echo};
        do @(posedge clk); while (!in_ready);
        sent_items++;
    endtask

    // Stops sending and waits until every predicted result has arrived.
    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (2 * LATENCY) @(posedge clk);
    endtask

    // Writes all three registers; only called once the block has drained.
    task automatic configure(input int settle, input int pulse, input int timeout);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_SETTLE;
        cfg_data <= CFG_W'(settle);
        @(posedge clk);
        cfg_idx  <= CFG_PULSE;
        cfg_data <= CFG_W'(pulse);
        @(posedge clk);
        cfg_idx  <= CFG_TIMEOUT;
        cfg_data <= CFG_W'(timeout);
        @(posedge clk);
        cfg_we   <= 1'b0;
        cur_settle  = settle;
        cur_pulse   = pulse;
        cur_timeout = timeout;
    endtask

    // One measurement: a start, echo noise through the trigger sequence, a
    // low stretch, a high stretch and a closing low tick. Start requests are
    // sprinkled in at the given rate.
    task automatic measure(input int wait_low, input int echo_high, input int start_pct);
        int trig_len;
        trig_len = 2 * cur_settle + ((cur_pulse == 0) ? 1 : cur_pulse) - 1;
        push_tick(1'b1, coin(50));
        repeat (trig_len) push_tick(coin(start_pct), coin(50));
        repeat (wait_low) push_tick(coin(start_pct), 1'b0);
        repeat (echo_high) push_tick(coin(start_pct), 1'b1);
        push_tick(1'b0, 1'b0);
    endtask

    // Stimulus and verdict.
    initial begin
        int goal;
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        in_item  <= '0;
        cfg_we   <= 1'b0;
        cfg_idx  <= CFG_SETTLE;
        cfg_data <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // A write to an unused index must leave the reset values in place.
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_UNUSED;
        cfg_data <= '1;
        @(posedge clk);
        cfg_we <= 1'b0;

        // Reset register values, plus idle ticks with both echo levels.
        push_tick(1'b0, 1'b1);
        push_tick(1'b0, 1'b0);

        // A start under the reset values, run until the trigger pulse has begun.
        push_tick(1'b1, 1'b0);
        repeat (cur_settle + 4) push_tick(1'b0, coin(50));

        // Registers written during the pulse take effect at once; with zero
        // settle, zero pulse and zero timeout the measurement then fails.
        drain();
        configure(0, 0, 0);
        push_tick(1'b0, 1'b0);
        push_tick(1'b0, 1'b0);
        measure(0, 1, 0);
        measure(1, 0, 0);

        // Short settle; echo wait and echo width on both sides of the limit.
        drain();
        configure(6, 1, 5);
        measure(5, 5, 0);
        measure(6, 0, 0);
        measure(0, 6, 0);

        // Start requests on every tick of a measurement are ignored.
        drain();
        configure(2, 3, 10);
        measure(3, 4, 100);

        // Longest timeout with a wide echo, run without gaps.
        drain();
        gaps_on = 1'b0;
        configure(3, 4, 16777215);
        measure(7, 40, 0);
        gaps_on = 1'b1;

        // Random phases of mostly well-formed measurements with noise between.
        for (int phase_no = 0; phase_no < 4; phase_no++) begin
            drain();
            configure($urandom_range(0, 4), $urandom_range(0, 6), $urandom_range(0, 25));
            gaps_on = (phase_no != 2);
            goal    = sent_items + 40;
            if (phase_no == 1) begin
                hold_req = 1'b1;
                while (hold_req) push_tick(coin(30), coin(50));
            end
            while (sent_items < goal) begin
                if (coin(80)) begin
                    measure($urandom_range(0, cur_timeout + 2),
                            $urandom_range(0, cur_timeout + 2), 5);
                end else begin
                    repeat ($urandom_range(1, 5)) push_tick(coin(30), coin(50));
                end
            end
        end
        gaps_on = 1'b1;

        drain();
        if (fail_count == 0 && pending == 0) begin
            $display("PASS ultrasonic_echo_ranger_top");
        end else begin
            $display("FAIL ultrasonic_echo_ranger_top");
        end
        $finish;
    end

endmodule
